// File: rtl/core/msort_pkg.sv
// Shared types and constants for the merge sorter.
// No dependencies; imported by every module of the block.
`default_nettype none

package msort_pkg;

  localparam int MSORT_DATA_W    = 32;
  localparam int MSORT_DEPTH_DEF = 64;

  typedef logic signed [MSORT_DATA_W-1:0] msort_data_t;

  // Input transaction payload
  typedef struct packed {
    msort_data_t value;
    logic        last_item;
  } msort_in_t;

  // Result transaction payload
  typedef struct packed {
    msort_data_t sorted_value;
    logic        last_result;
    logic        overflowed;
  } msort_out_t;

  // Run status handed to the compare/select unit
  typedef struct packed {
    logic a_ok;  // left run still has elements
    logic b_ok;  // right run still has elements
  } msort_run_t;

  // Decision returned by the compare/select unit
  typedef struct packed {
    logic        take_a;
    msort_data_t wr_data;
  } msort_sel_t;

endpackage

`default_nettype wire

// File: rtl/core/msort_ram.sv
// Element store: one write port and two registered read ports.
// Depends on msort_pkg for the data type.
`default_nettype none

module msort_ram
  import msort_pkg::*;
#(
  parameter  int DEPTH = MSORT_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire msort_data_t     wr_data,
  input  wire logic [AW-1:0]   rd_addr_a,
  input  wire logic [AW-1:0]   rd_addr_b,
  output msort_data_t          rd_data_a,
  output msort_data_t          rd_data_b
);

  msort_data_t mem [DEPTH];

  // Write one element
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register both read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// File: rtl/core/msort_merge_unit.sv
// Shared compare/select unit: picks the next element of a two-run merge.
// Depends on msort_pkg for the data and run status types.
`default_nettype none

module msort_merge_unit
  import msort_pkg::*;
(
  input  wire msort_data_t head_a,
  input  wire msort_data_t head_b,
  input  wire msort_run_t  run,
  output msort_sel_t       sel
);

  logic a_le_b;

  // Signed compare; ties go to the left run to keep the merge stable
  assign a_le_b = (head_a <= head_b);

  always_comb begin
    sel.take_a  = run.a_ok && (!run.b_ok || a_le_b);
    sel.wr_data = sel.take_a ? head_a : head_b;
  end

endmodule

`default_nettype wire

// File: rtl/core/merge_sorter_top.sv
// Merge sorter top level: load sequencer, merge pass sequencer and emit stage.
// Depends on msort_pkg, msort_ram and msort_merge_unit.
//
// Usage:
//   The in_ channel takes one signed value per transaction; last_item marks
//   the final value of a set. Values are written to the store one per cycle.
//   Values arriving once DEPTH are held are dropped and the overflowed flag
//   is set on every result of that set.
//   After the last value the block sorts bottom-up (run widths 1, 2, 4, ...)
//   with one compare/select unit that writes one element per cycle within
//   a pass, ping-ponging between two stores. A set of n elements takes
//   ceil(log2 n) passes, each begun from ST_PREP; ST_EMIT_PREP precedes
//   the first result. Results then leave on the out_ channel, one per
//   cycle while out_ready is high, the final one marked with last_result.
//   in_ready is low from the last value of a set until its final result
//   is taken. A stalled receiver holds the output register; the sequencer
//   waits. Reset (rst_n low, synchronous) empties the set and drops any
//   result not yet delivered.
`default_nettype none

module merge_sorter_top
  import msort_pkg::*;
#(
  parameter int DEPTH = MSORT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire msort_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output msort_out_t      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_MERGE,
    ST_EMIT_PREP,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [PW-1:0]   i_r, i_nxt;
  logic [PW-1:0]   mid_r, mid_nxt;
  logic [PW-1:0]   j_r, j_nxt;
  logic [PW-1:0]   hi_r, hi_nxt;
  logic [PW-1:0]   k_r, k_nxt;
  logic [PW-1:0]   w_r, w_nxt;
  logic            src_r, src_nxt;
  logic            out_valid_r, out_valid_nxt;
  msort_out_t      out_r, out_nxt;

  logic            in_acc;
  logic            has_room;
  logic [PW-1:0]   n_w;
  logic [PW-1:0]   w2;
  logic [PW-1:0]   lim_mid;
  logic [PW-1:0]   lim_hi;
  logic [PW-1:0]   rd_a_ptr;
  logic [PW-1:0]   rd_b_ptr;
  logic            can_load;

  msort_data_t     rd0_a, rd0_b, rd1_a, rd1_b;
  msort_data_t     head_a, head_b;
  msort_run_t      run;
  msort_sel_t      sel;

  logic            we0, we1;
  logic [AW-1:0]   wr0_addr;
  msort_data_t     wr0_data;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign has_room  = (cnt_r < CW'(DEPTH));
  assign n_w       = PW'(cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign can_load  = !out_valid_r || out_ready;

  // Select run heads from the current source store
  assign head_a  = src_r ? rd1_a : rd0_a;
  assign head_b  = src_r ? rd1_b : rd0_b;
  assign run.a_ok = (i_r < mid_r);
  assign run.b_ok = (j_r < hi_r);

  msort_merge_unit u_merge (
    .head_a (head_a),
    .head_b (head_b),
    .run    (run),
    .sel    (sel)
  );

  // Store writes: loading goes to store 0, merges go to the destination
  assign we0      = (in_acc && has_room) || ((state_r == ST_MERGE) && src_r);
  assign we1      = (state_r == ST_MERGE) && !src_r;
  assign wr0_addr = (state_r == ST_LOAD) ? cnt_r[AW-1:0] : k_r[AW-1:0];
  assign wr0_data = (state_r == ST_LOAD) ? in_data.value : sel.wr_data;

  msort_ram #(.DEPTH(DEPTH)) u_store0 (
    .clk       (clk),
    .we        (we0),
    .wr_addr   (wr0_addr),
    .wr_data   (wr0_data),
    .rd_addr_a (rd_a_ptr[AW-1:0]),
    .rd_addr_b (rd_b_ptr[AW-1:0]),
    .rd_data_a (rd0_a),
    .rd_data_b (rd0_b)
  );

  msort_ram #(.DEPTH(DEPTH)) u_store1 (
    .clk       (clk),
    .we        (we1),
    .wr_addr   (k_r[AW-1:0]),
    .wr_data   (sel.wr_data),
    .rd_addr_a (rd_a_ptr[AW-1:0]),
    .rd_addr_b (rd_b_ptr[AW-1:0]),
    .rd_data_a (rd1_a),
    .rd_data_b (rd1_b)
  );

  // Read addresses: prefetch the heads for the next cycle
  always_comb begin
    case (state_r)
      ST_PREP: begin
        rd_a_ptr = i_r;
        rd_b_ptr = j_r;
      end
      ST_MERGE: begin
        rd_a_ptr = i_nxt;
        rd_b_ptr = j_nxt;
      end
      ST_EMIT_PREP: begin
        rd_a_ptr = k_r;
        rd_b_ptr = k_r;
      end
      ST_EMIT: begin
        rd_a_ptr = k_nxt;
        rd_b_ptr = k_nxt;
      end
      default: begin
        rd_a_ptr = '0;
        rd_b_ptr = '0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    mid_nxt       = mid_r;
    j_nxt         = j_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    w2            = w_r << 1;
    lim_mid       = '0;
    lim_hi        = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            src_nxt = 1'b0;
            k_nxt   = '0;
            w_nxt   = PW'(1);
            i_nxt   = '0;
            mid_nxt = PW'(1);
            j_nxt   = PW'(1);
            hi_nxt  = PW'(2);
            // A single element needs no merging
            if (PW'(cnt_nxt) == PW'(1)) begin
              state_nxt = ST_EMIT_PREP;
            end else begin
              state_nxt = ST_PREP;
            end
          end
        end
      end

      ST_PREP: begin
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        k_nxt = k_r + 1'b1;
        if (sel.take_a) begin
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        if (k_nxt == hi_r) begin
          if (hi_r == n_w) begin
            // Pass done: swap stores and double the run width
            src_nxt = !src_r;
            w_nxt   = w2;
            k_nxt   = '0;
            if (w2 >= n_w) begin
              state_nxt = ST_EMIT_PREP;
            end else begin
              lim_mid   = (w2 > n_w) ? n_w : w2;
              lim_hi    = ((w2 << 1) > n_w) ? n_w : (w2 << 1);
              i_nxt     = '0;
              mid_nxt   = lim_mid;
              j_nxt     = lim_mid;
              hi_nxt    = lim_hi;
              state_nxt = ST_PREP;
            end
          end else begin
            // Advance to the next pair of runs in this pass
            lim_mid = ((hi_r + w_r) > n_w) ? n_w : (hi_r + w_r);
            lim_hi  = ((hi_r + w2) > n_w) ? n_w : (hi_r + w2);
            i_nxt   = hi_r;
            mid_nxt = lim_mid;
            j_nxt   = lim_mid;
            hi_nxt  = lim_hi;
            k_nxt   = hi_r;
          end
        end
      end

      ST_EMIT_PREP: begin
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (can_load) begin
          if (k_r < n_w) begin
            out_nxt.sorted_value = head_a;
            out_nxt.last_result  = ((k_r + 1'b1) == n_w);
            out_nxt.overflowed   = ovf_r;
            out_valid_nxt        = 1'b1;
            k_nxt                = k_r + 1'b1;
          end else begin
            // Final result taken: start a new set
            out_valid_nxt = 1'b0;
            cnt_nxt       = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      mid_r       <= '0;
      j_r         <= '0;
      hi_r        <= '0;
      k_r         <= '0;
      w_r         <= '0;
      src_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      mid_r       <= mid_nxt;
      j_r         <= j_nxt;
      hi_r        <= hi_nxt;
      k_r         <= k_nxt;
      w_r         <= w_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/msort_checker.sv
// Port-level checks for the merge sorter, bound to merge_sorter_top.
// Depends on msort_pkg for the payload types.
`default_nettype none

module msort_checker
  import msort_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire msort_in_t  in_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire msort_out_t out_data
);

  // Stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input and output sides are never open together
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while results pending");

  // Last value of a set closes the input
  a_close_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_item |=> !in_ready)
    else $error("input still open after last value");

  // Final result reopens the input with nothing pending
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_result |=> in_ready && !out_valid)
    else $error("set not closed after final result");

  // Reset drops pending results
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind merge_sorter_top msort_checker u_msort_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
